[rtl/assert_macros.svh]
// assertion macros shared by the filter rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fcg_pkg.sv]
// types and constants for the fir filter with clamp and gain
// no dependencies
package fcg_pkg;

  // request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b1;

  localparam logic [5:0]         TAPS_RESET = 6'd32;
  localparam logic signed [15:0] GAIN_RESET = 16'sd256;

  // sum clamp bounds in q15, 32767 * 2^15 and -32768 * 2^15
  localparam logic signed [31:0] SUM_MAX = 32'sh3FFF_8000;
  localparam logic signed [31:0] SUM_MIN = 32'shC000_0000;

  // multiplier product width and the bias for round half toward minus infinity
  localparam int                         PROD_W     = 48;
  localparam logic signed [PROD_W-1:0]   ROUND_BIAS = 48'sd4194303;
  localparam int                         FRAC_BITS  = 23;

  localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] OUT_MIN = 16'sh8000;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] sample_in;
    logic [4:0]        coef_index;
    logic signed [15:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic              clipped;
  } out_item_t;

  // step controls from the sequencer to the shared multiply unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic gain_sel;
    logic acc_en;
    logic clamp_en;
    logic round_en;
  } mac_ctrl_t;

endpackage

[rtl/fcg_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module fcg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fcg_mac.sv]
// shared multiplier with accumulator, sum clamp, rounding and output saturation
// depends on fcg_pkg
module fcg_mac #(
  parameter int ACC_W = 37
) (
  input  logic                clk,
  input  fcg_pkg::mac_ctrl_t  ctrl,
  input  logic signed [15:0]  dl_rd,
  input  logic signed [15:0]  coef_rd,
  input  logic signed [15:0]  gain,
  output fcg_pkg::out_item_t  result
);

  logic signed [31:0]                 mul_a;
  logic signed [15:0]                 mul_b;
  logic signed [fcg_pkg::PROD_W-1:0]  mul_full;
  logic signed [fcg_pkg::PROD_W-1:0]  prod_q;
  logic signed [fcg_pkg::PROD_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]            acc;
  logic signed [30:0]                 clamp_q;
  logic                               clip_sum;
  logic signed [24:0]                 rnd_q;
  logic                               sum_hi;
  logic                               sum_lo;
  logic                               out_hi;
  logic                               out_lo;

  // tap products use the delay line and coefficient, the gain step reuses the same multiplier
  assign mul_a    = ctrl.gain_sel ? 32'(clamp_q) : 32'(dl_rd);
  assign mul_b    = ctrl.gain_sel ? gain : coef_rd;
  assign mul_full = mul_a * mul_b;

  assign sum_hi = acc > ACC_W'(fcg_pkg::SUM_MAX);
  assign sum_lo = acc < ACC_W'(fcg_pkg::SUM_MIN);

  assign rnd_sum = prod_q + fcg_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_q <= mul_full;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'($signed(prod_q[31:0]));
    end
    if (ctrl.clamp_en) begin
      clamp_q  <= sum_hi ? fcg_pkg::SUM_MAX[30:0] :
                  sum_lo ? fcg_pkg::SUM_MIN[30:0] : acc[30:0];
      clip_sum <= sum_hi | sum_lo;
    end
    // floor shift of the biased product gives ceil(x - 0.5)
    if (ctrl.round_en) begin
      rnd_q <= rnd_sum[fcg_pkg::PROD_W-1:fcg_pkg::FRAC_BITS];
    end
  end

  assign out_hi = rnd_q > 25'(fcg_pkg::OUT_MAX);
  assign out_lo = rnd_q < 25'(fcg_pkg::OUT_MIN);

  always_comb begin
    result.sample_out = out_hi ? fcg_pkg::OUT_MAX :
                        out_lo ? fcg_pkg::OUT_MIN : rnd_q[15:0];
    result.clipped    = clip_sum | out_hi | out_lo;
  end

endmodule

[rtl/fir_filter_clamp_gain_top.sv]
// top level of the fir filter with clamp and gain: sequencer, config registers, output register
// depends on fcg_pkg, fcg_ram, fcg_mac and assert_macros.svh
// A coefficient load request leaves the block idle, so it can accept again straight away. A sample
// request keeps the block busy from acceptance until its result is loaded into the output register.
// The effective tap count is taps_in_use, with 0 read as 1 and values above NUM_TAPS read as
// NUM_TAPS: one shared multiplier handles one tap per cycle from the delay line and coefficient
// rams, then the pipeline drains and the sum is clamped, and the same multiplier applies the gain
// before rounding and saturation. After reset both rams are cleared in a pass over all addresses
// during which no request is accepted; configuration writes are taken at any time. The result sits
// in an output register, so the next request can be accepted while it waits.
`include "assert_macros.svh"

module fir_filter_clamp_gain_top #(
  parameter int NUM_TAPS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fcg_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fcg_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [fcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int ADDR_W   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int ACC_W    = 32 + $clog2(NUM_TAPS);
  localparam int TAPS_CAP = (NUM_TAPS < 63) ? NUM_TAPS : 63;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_TAPS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TAPS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_SAT   = 3'd6;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   rd_addr_d;
  logic [ADDR_W-1:0]   last_addr;
  logic [ADDR_W-1:0]   last_next;
  logic                rd_v;
  logic                mul_v;
  logic [5:0]          taps_in_use;
  logic signed [15:0]  output_gain;
  logic [5:0]          taps_lim;
  logic                in_accept;
  logic                sample_req;
  logic                coef_ok;
  logic                shift_we;
  logic                out_load;

  logic                dl_we;
  logic [ADDR_W-1:0]   dl_waddr;
  logic [15:0]         dl_wdata;
  logic [15:0]         dl_rd;
  logic                coef_we;
  logic [ADDR_W-1:0]   coef_waddr;
  logic [15:0]         coef_wdata;
  logic [15:0]         coef_rd;

  fcg_pkg::mac_ctrl_t  ctrl;
  fcg_pkg::out_item_t  mac_result;

  assign in_ready   = (state == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign sample_req = in_accept && (in_data.opcode == fcg_pkg::OP_SAMPLE);
  assign coef_ok    = (NUM_TAPS >= 32) || (32'(in_data.coef_index) < NUM_TAPS);
  assign shift_we   = rd_v && (rd_addr_d != '0);
  assign out_load   = (state == S_SAT) && (!out_valid || out_ready);

  // effective tap count: zero acts as one, capped at the line length
  assign taps_lim  = (taps_in_use == '0) ? 6'd1 :
                     (taps_in_use > 6'(TAPS_CAP)) ? 6'(TAPS_CAP) : taps_in_use;
  assign last_next = ADDR_W'(taps_lim - 6'd1);

  // delay line write port: clear sweep, newest sample, then one shift per tap read above address zero
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = rd_addr_d - ADDR_W'(1);
    dl_wdata = dl_rd;
    if (state == S_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = rd_addr;
      dl_wdata = '0;
    end else if (sample_req) begin
      dl_we    = 1'b1;
      dl_waddr = last_next;
      dl_wdata = in_data.sample_in;
    end else if (shift_we) begin
      dl_we    = 1'b1;
    end
  end

  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = ADDR_W'(in_data.coef_index);
    coef_wdata = in_data.coef_value;
    if (state == S_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = rd_addr;
      coef_wdata = '0;
    end else if (in_accept && in_data.opcode == fcg_pkg::OP_LOAD && coef_ok) begin
      coef_we    = 1'b1;
    end
  end

  always_comb begin
    ctrl.clear    = sample_req;
    ctrl.mul_en   = rd_v || (state == S_GAIN);
    ctrl.gain_sel = (state == S_GAIN);
    ctrl.acc_en   = mul_v;
    ctrl.clamp_en = (state == S_DRAIN) && !rd_v && !mul_v;
    ctrl.round_en = (state == S_ROUND);
  end

  fcg_ram #(.WIDTH(16), .DEPTH(NUM_TAPS)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (rd_addr),
    .rdata (dl_rd)
  );

  fcg_ram #(.WIDTH(16), .DEPTH(NUM_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (rd_addr),
    .rdata (coef_rd)
  );

  fcg_mac #(.ACC_W(ACC_W)) u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .dl_rd   (dl_rd),
    .coef_rd (coef_rd),
    .gain    (output_gain),
    .result  (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      rd_addr     <= '0;
      rd_v        <= 1'b0;
      mul_v       <= 1'b0;
      out_valid   <= 1'b0;
      taps_in_use <= fcg_pkg::TAPS_RESET;
      output_gain <= fcg_pkg::GAIN_RESET;
    end else begin
      rd_v  <= (state == S_TAPS);
      mul_v <= rd_v;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          fcg_pkg::REG_TAPS: taps_in_use <= cfg_data[5:0];
          fcg_pkg::REG_GAIN: output_gain <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          if (rd_addr == CLR_LAST) begin
            rd_addr <= '0;
            state   <= S_IDLE;
          end else begin
            rd_addr <= rd_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (sample_req) begin
            rd_addr <= '0;
            state   <= S_TAPS;
          end
        end
        S_TAPS: begin
          if (rd_addr == last_addr) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_v && !mul_v) begin
            state <= S_GAIN;
          end
        end
        S_GAIN:  state <= S_ROUND;
        S_ROUND: state <= S_SAT;
        S_SAT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_d <= rd_addr;
    if (sample_req) begin
      last_addr <= last_next;
    end
    if (out_load) begin
      out_data <= mac_result;
    end
  end

  `ASSERT_SAME(a_accept_idle_pipe, in_accept, !rd_v && !mul_v, "request accepted with taps in flight")
  `ASSERT_NEXT(a_sample_starts, sample_req, state == S_TAPS && rd_addr == '0, "sample did not start at tap zero")
  `ASSERT_NEXT(a_last_tap_drains, state == S_TAPS && rd_addr == last_addr, state == S_DRAIN, "tap loop overran")
  `ASSERT_SAME(a_shift_in_range, shift_we, rd_addr_d <= last_addr, "shift beyond active taps")
  `ASSERT_SAME(a_result_from_sat, $rose(out_valid), $past(state) == S_SAT, "result without saturation step")

endmodule
